// ===== rtl/sljc_pkg.sv =====
// Shared types, constants and fixed-point helpers for the switched LJ /
// implicit-dielectric Coulomb pair pipeline. No dependencies.
`timescale 1ns / 1ps

package sljc_pkg;

  // Divider layout: quotient bits resolved per stage and stage count
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = 64 / DIV_BITS;

  // Product rescaling shifts
  localparam int unsigned SH_Q48 = 48;
  localparam int unsigned SH_Q40 = 40;
  localparam int unsigned SH_Q16 = 16;

  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // Register reset values
  localparam logic [31:0] COUL_OUTER_RST = 32'd9437184;
  localparam logic [31:0] COUL_INNER_RST = 32'd6553600;
  localparam logic [31:0] LJ_OUTER_RST   = 32'd9437184;
  localparam logic [31:0] LJ_INNER_RST   = 32'd6553600;
  localparam logic [62:0] SW_DEN_RST     = 63'd1429150367744;
  localparam logic [31:0] ELEC_RST       = 32'd21757952;

  // Register map, one entry per 8-byte slot
  typedef enum logic [2:0] {
    REG_COUL_OUTER = 3'd0,
    REG_COUL_INNER = 3'd1,
    REG_LJ_OUTER   = 3'd2,
    REG_LJ_INNER   = 3'd3,
    REG_COUL_DEN   = 3'd4,
    REG_LJ_DEN     = 3'd5,
    REG_ELEC       = 3'd6
  } cfg_reg_e;

  // 64x64 product held as four 32x32 partial products plus result sign
  typedef struct packed {
    logic        neg;
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } mul_pp_t;

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic mul_pp_t mul_pp(input logic neg, input logic [63:0] a,
                                     input logic [63:0] b);
    mul_pp_t p;
    p.neg = neg;
    p.ll  = 64'(a[31:0])  * 64'(b[31:0]);
    p.lh  = 64'(a[31:0])  * 64'(b[63:32]);
    p.hl  = 64'(a[63:32]) * 64'(b[31:0]);
    p.hh  = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  // signed a times unsigned b
  function automatic mul_pp_t mul_pp_s(input logic [63:0] a, input logic [63:0] b);
    return mul_pp(a[63], mag(a), b);
  endfunction

  // Sum partials, shift down, saturate to 64 unsigned bits
  function automatic logic [63:0] mul_fin_u(input mul_pp_t p, input int unsigned sh);
    logic [127:0] full;
    logic [127:0] shv;
    full = {64'b0, p.ll} + {32'b0, p.lh, 32'b0} + {32'b0, p.hl, 32'b0} + {p.hh, 64'b0};
    shv  = full >> sh;
    return (|shv[127:64]) ? U64_MAX : shv[63:0];
  endfunction

  function automatic logic [63:0] sat_signed(input logic [63:0] m, input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = (m > S64_MAX) ? S64_MIN : (~m + 64'd1);
    end else begin
      r = (m > S64_MAX) ? S64_MAX : m;
    end
    return r;
  endfunction

  function automatic logic [63:0] mul_fin_s(input mul_pp_t p, input int unsigned sh);
    return sat_signed(mul_fin_u(p, sh), p.neg);
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] sum;
    sum = {a[63], a} + {b[63], b};
    if (sum[64] != sum[63]) begin
      return sum[64] ? S64_MIN : S64_MAX;
    end
    return sum[63:0];
  endfunction

  function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] dif;
    dif = {a[63], a} - {b[63], b};
    if (dif[64] != dif[63]) begin
      return dif[64] ? S64_MIN : S64_MAX;
    end
    return dif[63:0];
  endfunction

endpackage

// ===== rtl/sljc_div.sv =====
// Pipelined restoring divider: floor(hi:lo / den) for a 64-bit quotient,
// saturating when hi >= den. Uses sljc_pkg for the stage layout.
`timescale 1ns / 1ps

module sljc_div
  import sljc_pkg::*;
(
  input  logic        clk_i,
  input  logic [63:0] num_hi_i,
  input  logic [63:0] num_lo_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o
);

  typedef struct packed {
    logic        sat;
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] quo;
    logic [63:0] den;
  } div_st_t;

  // one restoring step: bring down a dividend bit, trial subtract
  function automatic div_st_t div_step(input div_st_t st);
    div_st_t     nx;
    logic [64:0] trial;
    logic        take;
    nx    = st;
    trial = {st.rem, st.lo[63]};
    take  = (trial >= {1'b0, st.den});
    if (take) begin
      trial = trial - {1'b0, st.den};
    end
    nx.rem = trial[63:0];
    nx.lo  = {st.lo[62:0], 1'b0};
    nx.quo = {st.quo[62:0], take};
    return nx;
  endfunction

  div_st_t st_q [DIV_STAGES];
  div_st_t st_d [DIV_STAGES];
  div_st_t init;

  // quotient overflow shows up as a high part not below the divisor
  always_comb begin
    init.sat = (num_hi_i >= den_i);
    init.rem = num_hi_i;
    init.lo  = num_lo_i;
    init.quo = '0;
    init.den = den_i;
  end

  // each stage resolves DIV_BITS quotient bits
  always_comb begin : stage_logic
    div_st_t cur;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cur = (k == 0) ? init : st_q[k-1];
      for (int b = 0; b < DIV_BITS; b++) begin
        cur = div_step(cur);
      end
      st_d[k] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].sat ? U64_MAX : st_q[DIV_STAGES-1].quo;

endmodule

// ===== rtl/switched_lj_implicit_coulomb_pair.sv =====
// Top level of the switched LJ / implicit-dielectric Coulomb pair pipeline.
// Depends on sljc_pkg and sljc_div.
`timescale 1ns / 1ps

// One atom pair enters per clock and its word comes out on force_over_r_o /
// pair_energy_o, marked by done_o for one cycle. The pipeline is made of
// the five 32-stage dividers (two quotient bits per stage) that form 1/r^2
// and the four switch factors, plus 5 front stages for the switch
// numerators and 17 back stages of split 64x64 multiplies.
// busy_o stays low: the pipeline never stalls, and the receiver must take
// each word in the cycle it is shown. Configure only while no pair is in
// flight.
module switched_lj_implicit_coulomb_pair
  import sljc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] dist_sq_i,
  input  logic signed [31:0] charge_a_i,
  input  logic signed [31:0] charge_b_i,
  input  logic signed [63:0] lj_force_rep_i,
  input  logic signed [63:0] lj_force_att_i,
  input  logic signed [63:0] lj_energy_rep_i,
  input  logic signed [63:0] lj_energy_att_i,
  input  logic [16:0] coul_scale_i,
  input  logic [16:0] lj_scale_i,
  output logic        done_o,
  output logic signed [63:0] force_over_r_o,
  output logic signed [63:0] pair_energy_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned LAT = 5 + DIV_STAGES + 17;

  typedef struct packed {
    logic [63:0] f12;
    logic [63:0] f6;
    logic [63:0] e12;
    logic [63:0] e6;
    logic [16:0] cs;
    logic [16:0] ls;
  } coef_t;

  typedef struct packed {
    logic c_act;
    logic c_sw;
    logic l_act;
    logic l_sw;
  } flags_t;

  typedef struct packed {
    coef_t       coef;
    flags_t      fl;
    logic [63:0] phi0;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [63:0] r2;
    logic [63:0] s1c;
    logic [63:0] s2c;
    logic [63:0] s1l;
    logic [63:0] s2l;
  } post_t;

  // ---------------- configuration registers ----------------
  logic [31:0] coul_outer_q, coul_inner_q, lj_outer_q, lj_inner_q, elec_q;
  logic [62:0] coul_den_q, lj_den_q;
  logic        cfg_wr;
  cfg_reg_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coul_outer_q <= COUL_OUTER_RST;
      coul_inner_q <= COUL_INNER_RST;
      lj_outer_q   <= LJ_OUTER_RST;
      lj_inner_q   <= LJ_INNER_RST;
      coul_den_q   <= SW_DEN_RST;
      lj_den_q     <= SW_DEN_RST;
      elec_q       <= ELEC_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COUL_OUTER: coul_outer_q <= pwdata[31:0];
        REG_COUL_INNER: coul_inner_q <= pwdata[31:0];
        REG_LJ_OUTER:   lj_outer_q   <= pwdata[31:0];
        REG_LJ_INNER:   lj_inner_q   <= pwdata[31:0];
        REG_COUL_DEN:   coul_den_q   <= pwdata[62:0];
        REG_LJ_DEN:     lj_den_q     <= pwdata[62:0];
        REG_ELEC:       elec_q       <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_COUL_OUTER: prdata = {32'b0, coul_outer_q};
      REG_COUL_INNER: prdata = {32'b0, coul_inner_q};
      REG_LJ_OUTER:   prdata = {32'b0, lj_outer_q};
      REG_LJ_INNER:   prdata = {32'b0, lj_inner_q};
      REG_COUL_DEN:   prdata = {1'b0, coul_den_q};
      REG_LJ_DEN:     prdata = {1'b0, lj_den_q};
      REG_ELEC:       prdata = {32'b0, elec_q};
      default:        prdata = '0;
    endcase
  end

  // per-term views: index 0 Coulomb, 1 LJ
  logic [31:0] outer_w [2];
  logic [31:0] inner_w [2];
  logic [62:0] den_w   [2];

  always_comb begin
    outer_w[0] = coul_outer_q;
    outer_w[1] = lj_outer_q;
    inner_w[0] = coul_inner_q;
    inner_w[1] = lj_inner_q;
    den_w[0]   = coul_den_q;
    den_w[1]   = lj_den_q;
  end

  // ---------------- valid pipeline ----------------
  logic [LAT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], start_i & ~busy_o};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = valid_q[LAT-1];

  // ---------------- front stages: switch numerators ----------------
  logic [31:0]        s_f_q    [5];
  coef_t              coef_f_q [5];
  flags_t             flags_f_q [1:4];
  logic signed [31:0] qa_q, qb_q;
  logic [63:0]        qq_q;
  logic [31:0]        dc_q  [2];
  logic [33:0]        t_q   [2];
  logic [35:0]        u_q   [2];
  logic [33:0]        t2_q  [2];
  logic [35:0]        u2_q  [2];
  logic [63:0]        dc2_q [2];
  logic [63:0]        sdc_q [2];
  mul_pp_t            phi_pp_q;
  logic [65:0]        pa_lo_q [2];
  logic [65:0]        pa_hi_q [2];
  logic [67:0]        pb_lo_q [2];
  logic [67:0]        pb_hi_q [2];
  logic [63:0]        phi0_f3_q, phi0_f4_q;
  logic [99:0]        num_q [4];

  flags_t      flags_d;
  logic [33:0] t_d [2];
  logic [35:0] u_d [2];

  // cutoff flags and switch operands from the captured distance
  always_comb begin : front_ops
    logic [35:0] tt;
    logic [35:0] d36;
    flags_d.c_act = s_f_q[0] < coul_outer_q;
    flags_d.c_sw  = (s_f_q[0] < coul_outer_q) && (s_f_q[0] > coul_inner_q);
    flags_d.l_act = s_f_q[0] < lj_outer_q;
    flags_d.l_sw  = (s_f_q[0] < lj_outer_q) && (s_f_q[0] > lj_inner_q);
    for (int m = 0; m < 2; m++) begin
      tt     = {4'b0, outer_w[m]} + {3'b0, s_f_q[0], 1'b0}
             - {3'b0, inner_w[m], 1'b0} - {4'b0, inner_w[m]};
      t_d[m] = tt[33:0];
      d36    = {4'b0, s_f_q[0] - inner_w[m]};
      u_d[m] = (d36 << 3) + (d36 << 2);
    end
  end

  always_ff @(posedge clk_i) begin
    // input capture
    s_f_q[0]    <= dist_sq_i;
    qa_q        <= charge_a_i;
    qb_q        <= charge_b_i;
    coef_f_q[0] <= '{f12: lj_force_rep_i, f6: lj_force_att_i,
                     e12: lj_energy_rep_i, e6: lj_energy_att_i,
                     cs: coul_scale_i, ls: lj_scale_i};
    for (int k = 1; k < 5; k++) begin
      s_f_q[k]    <= s_f_q[k-1];
      coef_f_q[k] <= coef_f_q[k-1];
    end
    flags_f_q[1] <= flags_d;
    for (int k = 2; k < 5; k++) begin
      flags_f_q[k] <= flags_f_q[k-1];
    end
    // F1: distance differences, charge product
    qq_q <= 64'(qa_q) * 64'(qb_q);
    for (int m = 0; m < 2; m++) begin
      dc_q[m] <= outer_w[m] - s_f_q[0];
      t_q[m]  <= t_d[m];
      u_q[m]  <= u_d[m];
    end
    // F2: 32x32 squares and products, charge times constant partials
    phi_pp_q <= mul_pp_s(qq_q, {32'b0, elec_q});
    for (int m = 0; m < 2; m++) begin
      dc2_q[m] <= 64'(dc_q[m]) * 64'(dc_q[m]);
      sdc_q[m] <= 64'(s_f_q[1]) * 64'(dc_q[m]);
      t2_q[m]  <= t_q[m];
      u2_q[m]  <= u_q[m];
    end
    // F3: split products with the cubic factors
    phi0_f3_q <= mul_fin_s(phi_pp_q, SH_Q40);
    for (int m = 0; m < 2; m++) begin
      pa_lo_q[m] <= 66'(dc2_q[m][31:0])  * 66'(t2_q[m]);
      pa_hi_q[m] <= 66'(dc2_q[m][63:32]) * 66'(t2_q[m]);
      pb_lo_q[m] <= 68'(sdc_q[m][31:0])  * 68'(u2_q[m]);
      pb_hi_q[m] <= 68'(sdc_q[m][63:32]) * 68'(u2_q[m]);
    end
    // F4: full numerators
    phi0_f4_q <= phi0_f3_q;
    for (int m = 0; m < 2; m++) begin
      num_q[2*m]   <= {34'b0, pa_lo_q[m]} + {2'b0, pa_hi_q[m], 32'b0};
      num_q[2*m+1] <= {32'b0, pb_lo_q[m]} + {pb_hi_q[m], 32'b0};
    end
  end

  // ---------------- dividers ----------------
  logic [63:0] sw_quo [4];
  logic [63:0] r2_quo;

  for (genvar g = 0; g < 4; g++) begin : g_sw_div
    sljc_div u_sw_div (
      .clk_i    (clk_i),
      .num_hi_i ({4'b0, num_q[g][99:40]}),
      .num_lo_i ({num_q[g][39:0], 24'b0}),
      .den_i    ({1'b0, den_w[g>>1]}),
      .quo_o    (sw_quo[g])
    );
  end

  // 2^64 / s, saturating for s of zero or one
  sljc_div u_r2_div (
    .clk_i    (clk_i),
    .num_hi_i (64'd1),
    .num_lo_i (64'd0),
    .den_i    ({32'b0, s_f_q[4]}),
    .quo_o    (r2_quo)
  );

  // side data rides alongside the dividers
  side_t side_d_q [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    side_d_q[0] <= '{coef: coef_f_q[4], fl: flags_f_q[4], phi0: phi0_f4_q};
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_d_q[k] <= side_d_q[k-1];
    end
  end

  // ---------------- back stages ----------------
  post_t ps_q [15];

  mul_pp_t pp_r4_q, pp_phi_q, pp_r6_q;
  mul_pp_t pp_a1_q, pp_a2_q, pp_m1_q, pp_m2_q, pp_m3_q;
  mul_pp_t pp_fl_q, pp_el_q, pp_n1_q, pp_n2_q, pp_n3_q;
  mul_pp_t pp_fc_q, pp_fl2_q, pp_ec_q, pp_el2_q, pp_fp_q;
  logic [63:0] r4_q, phi2_q, phi3_q, r6_4_q, fc4_q, phi4_q;
  logic [63:0] r6_5_q, fc5_q, phi5_q;
  logic [63:0] a1_q, a2_q, m1_q, m2_q, m3_q, r6_6_q, fc6_q, phi6_q;
  logic [63:0] b1_q, b2_q, fcs7_q, ecs7_q, r6_7_q;
  logic [63:0] fcs8_q, ecs8_q, fl9_q, el9_q, fcs9_q, ecs9_q;
  logic [63:0] fl10_q, el10_q, fcs10_q, ecs10_q;
  logic [63:0] n1_q, n2_q, n3_q, fl11_q, el11_q, fcs11_q, ecs11_q;
  logic [63:0] fls12_q, els12_q, fcs12_q, ecs12_q;
  logic [63:0] sfc_q, sfl_q, sec_q, sel_q;
  logic [63:0] fp_q, eng15_q, eng16_q, force_q, eng17_q;

  always_ff @(posedge clk_i) begin
    // side pipeline
    ps_q[0] <= '{sd: side_d_q[DIV_STAGES-1], r2: r2_quo, s1c: sw_quo[0],
                 s2c: sw_quo[1], s1l: sw_quo[2], s2l: sw_quo[3]};
    for (int k = 1; k < 15; k++) begin
      ps_q[k] <= ps_q[k-1];
    end
    // P1-P2: r^-4 and Coulomb energy
    pp_r4_q  <= mul_pp(1'b0, r2_quo, r2_quo);
    pp_phi_q <= mul_pp_s(side_d_q[DIV_STAGES-1].phi0, r2_quo);
    r4_q     <= mul_fin_u(pp_r4_q, SH_Q48);
    phi2_q   <= mul_fin_s(pp_phi_q, SH_Q48);
    // P3-P4: r^-6, Coulomb force
    pp_r6_q <= mul_pp(1'b0, r4_q, ps_q[1].r2);
    phi3_q  <= phi2_q;
    r6_4_q  <= mul_fin_u(pp_r6_q, SH_Q48);
    fc4_q   <= add_sat(phi3_q, phi3_q);
    phi4_q  <= phi3_q;
    // P5-P6: LJ inner products, Coulomb switch products
    pp_a1_q <= mul_pp_s(ps_q[3].sd.coef.f12, r6_4_q);
    pp_a2_q <= mul_pp_s(ps_q[3].sd.coef.e12, r6_4_q);
    pp_m1_q <= mul_pp_s(fc4_q, ps_q[3].s1c);
    pp_m2_q <= mul_pp_s(phi4_q, ps_q[3].s2c);
    pp_m3_q <= mul_pp_s(phi4_q, ps_q[3].s1c);
    r6_5_q  <= r6_4_q;
    fc5_q   <= fc4_q;
    phi5_q  <= phi4_q;
    a1_q    <= mul_fin_s(pp_a1_q, SH_Q48);
    a2_q    <= mul_fin_s(pp_a2_q, SH_Q48);
    m1_q    <= mul_fin_s(pp_m1_q, SH_Q48);
    m2_q    <= mul_fin_s(pp_m2_q, SH_Q48);
    m3_q    <= mul_fin_s(pp_m3_q, SH_Q48);
    r6_6_q  <= r6_5_q;
    fc6_q   <= fc5_q;
    phi6_q  <= phi5_q;
    // P7: LJ brackets, Coulomb switch select and cutoff
    b1_q   <= sub_sat(a1_q, ps_q[5].sd.coef.f6);
    b2_q   <= sub_sat(a2_q, ps_q[5].sd.coef.e6);
    fcs7_q <= !ps_q[5].sd.fl.c_act ? '0 :
              (ps_q[5].sd.fl.c_sw ? add_sat(m1_q, m2_q) : fc6_q);
    ecs7_q <= !ps_q[5].sd.fl.c_act ? '0 : (ps_q[5].sd.fl.c_sw ? m3_q : phi6_q);
    r6_7_q <= r6_6_q;
    // P8-P9: LJ force and energy
    pp_fl_q <= mul_pp_s(b1_q, r6_7_q);
    pp_el_q <= mul_pp_s(b2_q, r6_7_q);
    fcs8_q  <= fcs7_q;
    ecs8_q  <= ecs7_q;
    fl9_q   <= mul_fin_s(pp_fl_q, SH_Q48);
    el9_q   <= mul_fin_s(pp_el_q, SH_Q48);
    fcs9_q  <= fcs8_q;
    ecs9_q  <= ecs8_q;
    // P10-P11: LJ switch products
    pp_n1_q <= mul_pp_s(fl9_q, ps_q[8].s1l);
    pp_n2_q <= mul_pp_s(el9_q, ps_q[8].s2l);
    pp_n3_q <= mul_pp_s(el9_q, ps_q[8].s1l);
    fl10_q  <= fl9_q;
    el10_q  <= el9_q;
    fcs10_q <= fcs9_q;
    ecs10_q <= ecs9_q;
    n1_q    <= mul_fin_s(pp_n1_q, SH_Q48);
    n2_q    <= mul_fin_s(pp_n2_q, SH_Q48);
    n3_q    <= mul_fin_s(pp_n3_q, SH_Q48);
    fl11_q  <= fl10_q;
    el11_q  <= el10_q;
    fcs11_q <= fcs10_q;
    ecs11_q <= ecs10_q;
    // P12: LJ switch select and cutoff
    fls12_q <= !ps_q[10].sd.fl.l_act ? '0 :
               (ps_q[10].sd.fl.l_sw ? add_sat(n1_q, n2_q) : fl11_q);
    els12_q <= !ps_q[10].sd.fl.l_act ? '0 : (ps_q[10].sd.fl.l_sw ? n3_q : el11_q);
    fcs12_q <= fcs11_q;
    ecs12_q <= ecs11_q;
    // P13-P14: special-bond scaling
    pp_fc_q  <= mul_pp_s(fcs12_q, {47'b0, ps_q[11].sd.coef.cs});
    pp_fl2_q <= mul_pp_s(fls12_q, {47'b0, ps_q[11].sd.coef.ls});
    pp_ec_q  <= mul_pp_s(ecs12_q, {47'b0, ps_q[11].sd.coef.cs});
    pp_el2_q <= mul_pp_s(els12_q, {47'b0, ps_q[11].sd.coef.ls});
    sfc_q    <= mul_fin_s(pp_fc_q, SH_Q16);
    sfl_q    <= mul_fin_s(pp_fl2_q, SH_Q16);
    sec_q    <= mul_fin_s(pp_ec_q, SH_Q16);
    sel_q    <= mul_fin_s(pp_el2_q, SH_Q16);
    // P15: sums
    fp_q    <= add_sat(sfc_q, sfl_q);
    eng15_q <= add_sat(sec_q, sel_q);
    // P16-P17: force over r
    pp_fp_q <= mul_pp_s(fp_q, ps_q[14].r2);
    eng16_q <= eng15_q;
    force_q <= mul_fin_s(pp_fp_q, SH_Q48);
    eng17_q <= eng16_q;
  end

  assign force_over_r_o = force_q;
  assign pair_energy_o  = eng17_q;

`ifndef SYNTH
  // every result word traces back to a matching start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result word without matching start");

  // and every start produces a result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("start did not produce a result word");
`endif

endmodule

// ===== test/switched_lj_implicit_coulomb_pair_tb.sv =====
// Self-checking testbench for the switched LJ / implicit-dielectric Coulomb pair block.
// Depends on sljc_pkg and the switched_lj_implicit_coulomb_pair RTL.
`timescale 1ns / 1ps

module switched_lj_implicit_coulomb_pair_tb;
  import sljc_pkg::*;

  localparam int unsigned PIPE_LAT   = 54;
  localparam int unsigned DRAIN_WAIT = PIPE_LAT + 10;
  localparam int unsigned STALL_MAX  = 4000;
  localparam logic [63:0] CHG_ONE    = 64'd1 << 24;
  localparam logic [16:0] SCALE_ONE  = 17'd65536;

  typedef struct packed {
    logic [31:0] dist_sq;
    logic [31:0] charge_a;
    logic [31:0] charge_b;
    logic [63:0] f_rep;
    logic [63:0] f_att;
    logic [63:0] e_rep;
    logic [63:0] e_att;
    logic [16:0] coul_scale;
    logic [16:0] lj_scale;
  } pair_t;

  typedef struct packed {
    logic [63:0] force_r;
    logic [63:0] energy;
  } pair_out_t;

  typedef struct packed {
    pair_t     pair;
    logic      typed;
    pair_out_t known;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] dist_sq_i = '0;
  logic signed [31:0] charge_a_i = '0;
  logic signed [31:0] charge_b_i = '0;
  logic signed [63:0] lj_force_rep_i = '0;
  logic signed [63:0] lj_force_att_i = '0;
  logic signed [63:0] lj_energy_rep_i = '0;
  logic signed [63:0] lj_energy_att_i = '0;
  logic [16:0] coul_scale_i = '0;
  logic [16:0] lj_scale_i = '0;
  logic        done_o;
  logic signed [63:0] force_over_r_o;
  logic signed [63:0] pair_energy_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  switched_lj_implicit_coulomb_pair i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .dist_sq_i, .charge_a_i, .charge_b_i,
    .lj_force_rep_i, .lj_force_att_i, .lj_energy_rep_i, .lj_energy_att_i,
    .coul_scale_i, .lj_scale_i, .done_o, .force_over_r_o, .pair_energy_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the register file
  logic [63:0] coul_outer, coul_inner, lj_outer, lj_inner;
  logic [63:0] coul_den, lj_den, elec_k;

  pair_out_t   expected_q[$];
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;

  // ---------------- fixed-point predictor ----------------
  function automatic logic [63:0] umul_shr(input logic [63:0] a, input logic [63:0] b,
                                           input int unsigned sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    return (|p[127:64]) ? U64_MAX : p[63:0];
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [63:0] sat_mag(input logic [63:0] m, input logic neg);
    if (m > S64_MAX) return neg ? S64_MIN : S64_MAX;
    return neg ? (~m + 64'd1) : m;
  endfunction

  function automatic logic [63:0] smul_shr(input logic [63:0] a, input logic [63:0] b,
                                           input int unsigned sh);
    return sat_mag(umul_shr(abs64(a), b, sh), a[63]);
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic subtract);
    logic [64:0] r;
    r = subtract ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (r[64] != r[63]) return r[64] ? S64_MIN : S64_MAX;
    return r[63:0];
  endfunction

  function automatic logic [63:0] switch_quot(input logic [127:0] num, input logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return U64_MAX;
    q = (num << 24) / {64'b0, den};
    return (|q[127:64]) ? U64_MAX : q[63:0];
  endfunction

  // CHARMM switch: energy factor and force correction, valid for inner < s < outer
  task automatic switch_terms(input logic [63:0] outer, input logic [63:0] inner,
                              input logic [63:0] s, input logic [63:0] den,
                              output logic [63:0] sw_e, output logic [63:0] sw_f);
    logic [63:0] dc, t;
    dc = outer - s;
    t = outer + 2 * s - 3 * inner;
    sw_e = switch_quot({64'b0, dc * dc} * {64'b0, t}, den);
    sw_f = switch_quot({64'b0, s * dc} * {64'b0, 12 * (s - inner)}, den);
  endtask

  task automatic predict_pair(input pair_t p, output pair_out_t r);
    logic [63:0] s, r2inv, r6inv, qq, phi, sw_e, sw_f;
    logic [63:0] fc, fl, ec, el, fpair;
    fc = '0; fl = '0; ec = '0; el = '0;
    s = {32'b0, p.dist_sq};
    if (s <= 1) r2inv = U64_MAX;
    else r2inv = 64'((128'd1 << 64) / {64'b0, s});
    if (s < coul_outer) begin
      qq = {{32{p.charge_a[31]}}, p.charge_a} * {{32{p.charge_b[31]}}, p.charge_b};
      phi = smul_shr(smul_shr(qq, elec_k, 40), r2inv, 48);
      ec = phi;
      fc = sat_sum(phi, phi, 1'b0);
      if (s > coul_inner) begin
        switch_terms(coul_outer, coul_inner, s, coul_den, sw_e, sw_f);
        fc = sat_sum(smul_shr(fc, sw_e, 48), smul_shr(phi, sw_f, 48), 1'b0);
        ec = smul_shr(phi, sw_e, 48);
      end
    end
    if (s < lj_outer) begin
      r6inv = umul_shr(umul_shr(r2inv, r2inv, 48), r2inv, 48);
      fl = smul_shr(sat_sum(smul_shr(p.f_rep, r6inv, 48), p.f_att, 1'b1), r6inv, 48);
      el = smul_shr(sat_sum(smul_shr(p.e_rep, r6inv, 48), p.e_att, 1'b1), r6inv, 48);
      if (s > lj_inner) begin
        switch_terms(lj_outer, lj_inner, s, lj_den, sw_e, sw_f);
        fl = sat_sum(smul_shr(fl, sw_e, 48), smul_shr(el, sw_f, 48), 1'b0);
        el = smul_shr(el, sw_e, 48);
      end
    end
    fpair = sat_sum(smul_shr(fc, {47'b0, p.coul_scale}, 16),
                    smul_shr(fl, {47'b0, p.lj_scale}, 16), 1'b0);
    r.force_r = smul_shr(fpair, r2inv, 48);
    r.energy = sat_sum(smul_shr(ec, {47'b0, p.coul_scale}, 16),
                       smul_shr(el, {47'b0, p.lj_scale}, 16), 1'b0);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    pair_out_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word force=%h energy=%h", $time,
                 force_over_r_o, pair_energy_o);
      end else begin
        want = expected_q.pop_front();
        if (force_over_r_o !== want.force_r) begin
          err_cnt++;
          $display("%0t: force_over_r expected %h actual %h", $time,
                   want.force_r, force_over_r_o);
        end
        if (pair_energy_o !== want.energy) begin
          err_cnt++;
          $display("%0t: pair_energy expected %h actual %h", $time,
                   want.energy, pair_energy_o);
        end
      end
    end
  end

  // Watchdog: cycles without any accepted word, result or register access
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- config port ----------------
  task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] val);
    logic [63:0] v;
    v = (idx == REG_COUL_DEN || idx == REG_LJ_DEN) ? (val & S64_MAX) : {32'b0, val[31:0]};
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back in the same transfer style
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== v) begin
      err_cnt++;
      $display("%0t: readback reg %0d expected %h actual %h", $time, idx, v, prdata);
    end
    psel <= 1'b0; penable <= 1'b0;
    // return the bus to idle between transfers
    @(posedge clk_i);
    case (idx)
      REG_COUL_OUTER: coul_outer = v;
      REG_COUL_INNER: coul_inner = v;
      REG_LJ_OUTER:   lj_outer = v;
      REG_LJ_INNER:   lj_inner = v;
      REG_COUL_DEN:   coul_den = v;
      REG_LJ_DEN:     lj_den = v;
      REG_ELEC:       elec_k = v;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [31:0] c_out, input logic [31:0] c_in,
                         input logic [31:0] l_out, input logic [31:0] l_in,
                         input logic [63:0] c_den, input logic [63:0] l_den,
                         input logic [31:0] k);
    cfg_write(REG_COUL_OUTER, {32'b0, c_out});
    cfg_write(REG_COUL_INNER, {32'b0, c_in});
    cfg_write(REG_LJ_OUTER, {32'b0, l_out});
    cfg_write(REG_LJ_INNER, {32'b0, l_in});
    cfg_write(REG_COUL_DEN, c_den);
    cfg_write(REG_LJ_DEN, l_den);
    cfg_write(REG_ELEC, {32'b0, k});
  endtask

  // ---------------- stimulus ----------------
  // Present one word; start stays high across back-to-back words
  task automatic send_pair(input pair_t p, input logic typed, input pair_out_t known);
    pair_out_t want;
    if (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    dist_sq_i <= p.dist_sq; charge_a_i <= p.charge_a; charge_b_i <= p.charge_b;
    lj_force_rep_i <= p.f_rep; lj_force_att_i <= p.f_att;
    lj_energy_rep_i <= p.e_rep; lj_energy_att_i <= p.e_att;
    coul_scale_i <= p.coul_scale; lj_scale_i <= p.lj_scale;
    do @(posedge clk_i); while (busy_o);
    if (typed) want = known;
    else predict_pair(p, want);
    expected_q.push_back(want);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_coef();
    logic [63:0] v;
    case ($urandom_range(9, 0))
      0: v = S64_MAX;
      1: v = S64_MIN;
      2: v = {$urandom, $urandom};
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(63, 20);
        if ($urandom_range(1, 0)) v = ~v + 64'd1;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_charge();
    logic [31:0] v;
    if ($urandom_range(7, 0) == 0) return $urandom;
    v = $urandom_range(32'h0400_0000, 0);
    return $urandom_range(1, 0) ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] rand_dist();
    logic [63:0] hi;
    hi = (coul_outer > lj_outer) ? coul_outer : lj_outer;
    case ($urandom_range(9, 0))
      0: return $urandom;
      1: return 32'(coul_inner + $urandom_range(2, 0) - 1);
      2: return 32'(lj_outer + $urandom_range(2, 0) - 1);
      3: return $urandom_range(4, 0);
      default: begin
        if (hi == 0 || hi > 64'h6000_0000) return $urandom >> $urandom_range(31, 0);
        return $urandom_range(32'(hi + hi / 4), 0);
      end
    endcase
  endfunction

  function automatic logic [16:0] rand_scale();
    case ($urandom_range(5, 0))
      0: return 17'd0;
      1: return 17'h1FFFF;
      2, 3: return SCALE_ONE;
      default: return 17'($urandom_range(131071, 0));
    endcase
  endfunction

  task automatic random_pairs(input int unsigned n);
    pair_t p;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 30 == 0) begin
        case ((i / 30) % 3)
          0: sender_idle_pct = 0;
          1: sender_idle_pct = 77;
          default: sender_idle_pct = 20;
        endcase
      end
      p.dist_sq = rand_dist();
      p.charge_a = rand_charge();
      p.charge_b = rand_charge();
      p.f_rep = rand_coef(); p.f_att = rand_coef();
      p.e_rep = rand_coef(); p.e_att = rand_coef();
      p.coul_scale = rand_scale();
      p.lj_scale = rand_scale();
      send_pair(p, 1'b0, '0);
    end
  endtask

  stim_row_t   stim_rows[16];

  initial begin
    pair_t base;
    coul_outer = COUL_OUTER_RST; coul_inner = COUL_INNER_RST;
    lj_outer = LJ_OUTER_RST;     lj_inner = LJ_INNER_RST;
    coul_den = SW_DEN_RST;       lj_den = SW_DEN_RST;
    elec_k = ELEC_RST;

    // Directed rows; typed results only where the answer is plainly zero
    base = '{32'd0, 32'd0, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0, SCALE_ONE, SCALE_ONE};
    foreach (stim_rows[i]) stim_rows[i] = '{base, 1'b0, '0};
    stim_rows[0].typed = 1'b1;                                    // all zero at r = 0
    stim_rows[1].pair.charge_a = 32'(CHG_ONE); stim_rows[1].pair.charge_b = 32'(CHG_ONE);
    stim_rows[2].pair = '{32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, S64_MAX, S64_MIN,
                          S64_MAX, S64_MIN, SCALE_ONE, SCALE_ONE};
    // far beyond both cutoffs
    stim_rows[3] = '{'{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, S64_MAX, S64_MIN,
                       S64_MAX, S64_MIN, 17'h1FFFF, 17'h1FFFF}, 1'b1, '0};
    // exactly at the outer cutoff
    stim_rows[4] = '{'{COUL_OUTER_RST, 32'(CHG_ONE), 32'(CHG_ONE), 64'd1 << 40, 64'd1 << 30,
                       64'd1 << 40, 64'd1 << 30, SCALE_ONE, SCALE_ONE}, 1'b1, '0};
    stim_rows[5].pair = stim_rows[4].pair; stim_rows[5].pair.dist_sq = COUL_OUTER_RST - 1;
    stim_rows[6].pair = stim_rows[4].pair; stim_rows[6].pair.dist_sq = COUL_INNER_RST;
    stim_rows[7].pair = stim_rows[4].pair; stim_rows[7].pair.dist_sq = COUL_INNER_RST + 1;
    stim_rows[8].pair = stim_rows[4].pair; stim_rows[8].pair.dist_sq = 32'd120 << 16;
    stim_rows[9].pair = '{32'd4 << 16, 32'h8000_0000, 32'h8000_0000, 64'd0, 64'd0,
                          64'd0, 64'd0, SCALE_ONE, SCALE_ONE};
    stim_rows[10].pair = stim_rows[9].pair; stim_rows[10].pair.charge_b = 32'h7FFF_FFFF;
    stim_rows[11].pair = '{32'd1 << 16, 32'd0, 32'd0, S64_MAX, S64_MIN, S64_MIN, S64_MAX,
                           SCALE_ONE, SCALE_ONE};
    // both special-bond factors zero
    stim_rows[12] = '{'{32'd9 << 16, 32'h0100_0000, 32'hFF00_0000, S64_MAX, 64'd5,
                        64'd7, S64_MIN, 17'd0, 17'd0}, 1'b1, '0};
    stim_rows[13].pair = stim_rows[12].pair;
    stim_rows[13].pair.coul_scale = 17'h1FFFF; stim_rows[13].pair.lj_scale = 17'h1FFFF;
    stim_rows[14].pair = stim_rows[1].pair; stim_rows[14].pair.dist_sq = 32'd2;
    stim_rows[15].pair = '{32'd16 << 16, 32'hFF80_0000, 32'h0080_0000, 64'd3 << 40,
                           64'd5 << 34, 64'd1 << 39, 64'd5 << 33, 17'd32768, SCALE_ONE};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) send_pair(stim_rows[i].pair, stim_rows[i].typed,
                                     stim_rows[i].known);
    random_pairs(90);
    drain();

    // 10 A outer, 8 A inner
    cfg_all(32'd100 << 16, 32'd64 << 16, 32'd100 << 16, 32'd64 << 16,
            64'd46656 << 24, 64'd46656 << 24, 32'd20 << 16);
    random_pairs(90);
    drain();

    // inner at or above outer: never switched; tiny denominators
    cfg_all(32'd36 << 16, 32'hFFFF_FFFF, 32'd49 << 16, 32'd49 << 16, 64'd1, 64'd1,
            32'hFFFF_FFFF);
    random_pairs(90);
    drain();

    // widest windows, largest denominators
    cfg_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, S64_MAX, S64_MAX, ELEC_RST);
    random_pairs(90);
    drain();

    // everything cut off, zero constant, then mixed windows
    cfg_all(32'd0, 32'd0, 32'd0, 32'd0, 64'd1, 64'd1, 32'd0);
    random_pairs(20);
    drain();
    cfg_all(32'd144 << 16, 32'd81 << 16, 32'd64 << 16, 32'd1 << 16,
            64'd250047 << 24, 64'd250047 << 24, ELEC_RST);
    random_pairs(70);
    drain();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
